// File: hdl/npi_pkg.sv
// Shared types, constants and saturation helpers for the Neville interpolator.
// Used by npi_ctrl, npi_datapath and neville_polynomial_interpolator.
package npi_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PU_W           = 4;
  localparam logic [PU_W-1:0] PU_RESET = 4'd8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

  typedef struct packed {
    logic              command;
    logic [2:0]        point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } req_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic signed [31:0] error_estimate;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic start;
    logic search;
    logic prep;
    logic div_setup;
    logic div_step;
    logic div_fin;
    logic mul_d;
    logic mul_c;
    logic wr_c;
    logic path;
    logic fail;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic search_last;
    logic den_zero;
    logic div_last;
    logic row_last;
    logic eval_last;
  } ctl_sts_t;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // Saturate a sign and magnitude pair to a signed 32-bit word.
  function automatic logic signed [31:0] sat_signmag(input logic [64:0] mag, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (mag > 65'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > 65'h8000_0000) ? 32'sh8000_0000 : 32'(-mag[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/npi_ctrl.sv
// Sequencing state machine for the Neville interpolator.
// Depends on npi_pkg; drives npi_datapath by command and status structs.
module npi_ctrl import npi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_command,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, SEARCH, PREP, DSETUP, DSTEP, DFIN, MULD, MULC, WRC, PATH, DONE
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign req_stall = (state != IDLE);
  assign accept    = req_valid && (state == IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          if (req_command == CMD_EVAL) begin
            cmd.start  = 1'b1;
            state_next = SEARCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_last) state_next = PREP;
      end
      PREP: begin
        cmd.prep   = 1'b1;
        state_next = DSETUP;
      end
      DSETUP: begin
        if (sts.den_zero) begin
          cmd.fail   = 1'b1;
          state_next = DONE;
        end else begin
          cmd.div_setup = 1'b1;
          state_next    = DSTEP;
        end
      end
      DSTEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = DFIN;
      end
      DFIN: begin
        cmd.div_fin = 1'b1;
        state_next  = MULD;
      end
      MULD: begin
        cmd.mul_d  = 1'b1;
        state_next = MULC;
      end
      MULC: begin
        cmd.mul_c  = 1'b1;
        state_next = WRC;
      end
      WRC: begin
        cmd.wr_c   = 1'b1;
        state_next = sts.row_last ? PATH : DSETUP;
      end
      PATH: begin
        cmd.path   = 1'b1;
        state_next = sts.eval_last ? DONE : DSETUP;
      end
      DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/npi_datapath.sv
// Sample table, Neville tableau storage, shared divider and multiplier.
// Depends on npi_pkg; sequenced by npi_ctrl.
module npi_datapath import npi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  req_t            req,
  input  logic            cfg_we,
  input  logic [PU_W-1:0] cfg_data,
  input  ctl_cmd_t        cmd,
  output ctl_sts_t        sts,
  output rsp_t            rsp
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int NUM_W = 33 + FRAC_BITS;

  logic signed [31:0] xs [MAX_POINTS];
  logic signed [31:0] ys [MAX_POINTS];
  logic signed [31:0] cc [MAX_POINTS];
  logic signed [31:0] dd [MAX_POINTS];

  logic [PU_W-1:0]    points_used;
  logic signed [31:0] qx;
  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   i, k, m;
  logic [32:0]        best;
  logic signed [31:0] y, dy;
  logic               fail;
  logic [33:0]        rem;
  logic [31:0]        nsh, quo;
  logic [32:0]        dmag;
  logic               rneg, rovf;
  logic signed [31:0] ratio;
  logic [64:0]        prod;
  logic               pneg;
  logic [4:0]         dcnt;

  logic [CNT_W-1:0]   n_clamp;
  logic [IDX_W-1:0]   ip, i1, km1;
  logic signed [32:0] qx_e, ho, hp, den, w, ysum;
  logic [32:0]        qdist, ho_mag, hp_mag, w_mag, den_mag;
  logic [NUM_W-1:0]   num;
  logic [31:0]        rmag;
  logic [33:0]        trial;
  logic               take_c;
  logic signed [31:0] dy_new;

  always_comb begin
    if (points_used < 4'd2) begin
      n_clamp = CNT_W'(2);
    end else if (int'(points_used) > MAX_POINTS) begin
      n_clamp = CNT_W'(MAX_POINTS);
    end else begin
      n_clamp = CNT_W'(points_used);
    end
  end

  assign ip   = IDX_W'({1'b0, i} + {1'b0, m});
  assign i1   = IDX_W'({1'b0, i} + 1'b1);
  assign km1  = IDX_W'(k - 1'b1);
  assign qx_e = {qx[31], qx};
  assign ho   = {xs[i][31], xs[i]} - qx_e;
  assign hp   = {xs[ip][31], xs[ip]} - qx_e;
  assign den  = {xs[i][31], xs[i]} - {xs[ip][31], xs[ip]};
  assign w    = {cc[i1][31], cc[i1]} - {dd[i][31], dd[i]};
  assign qdist = abs33(qx_e - {xs[i][31], xs[i]});
  assign ho_mag  = abs33(ho);
  assign hp_mag  = abs33(hp);
  assign w_mag   = abs33(w);
  assign den_mag = abs33(den);
  assign num     = {w_mag, {FRAC_BITS{1'b0}}};
  assign rmag    = ratio[31] ? 32'(-ratio) : 32'(ratio);
  assign trial   = {rem[32:0], nsh[31]};

  // Path choice: go up the tableau while the nearest index sits in the lower half.
  assign take_c = ((CNT_W + 1)'(k) << 1) < (CNT_W + 1)'(n - CNT_W'(m));
  assign dy_new = take_c ? cc[k] : dd[km1];
  assign ysum   = {y[31], y} + {dy_new[31], dy_new};

  assign sts.search_last = (CNT_W'(i) == n - 1'b1);
  assign sts.den_zero    = (den == 33'sd0);
  assign sts.div_last    = (dcnt == 5'd31);
  assign sts.row_last    = (CNT_W'(i) == n - CNT_W'(m) - 1'b1);
  assign sts.eval_last   = (CNT_W'(m) == n - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_used <= PU_RESET;
    end else if (cfg_we) begin
      points_used <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (int'(req.point_index) < MAX_POINTS)) begin
      xs[IDX_W'(req.point_index)] <= req.point_x;
      ys[IDX_W'(req.point_index)] <= req.point_y;
    end

    if (cmd.start) begin
      qx   <= req.query_x;
      n    <= n_clamp;
      i    <= '0;
      k    <= '0;
      fail <= 1'b0;
    end

    if (cmd.search) begin
      if ((i == '0) || (qdist < best)) begin
        best <= qdist;
        k    <= i;
      end
      cc[i] <= ys[i];
      dd[i] <= ys[i];
      i     <= IDX_W'(i + 1'b1);
    end

    if (cmd.prep) begin
      y  <= ys[k];
      dy <= '0;
      m  <= IDX_W'(1);
      i  <= '0;
    end

    if (cmd.fail) fail <= 1'b1;

    if (cmd.div_setup) begin
      // The quotient keeps 32 bits; anything larger is flagged and saturated.
      rem  <= 34'(num[NUM_W-1:32]);
      nsh  <= num[31:0];
      quo  <= '0;
      dmag <= den_mag;
      rneg <= w[32] ^ den[32];
      rovf <= 65'(num) >= {den_mag, 32'b0};
      dcnt <= '0;
    end

    if (cmd.div_step) begin
      if (trial >= {1'b0, dmag}) begin
        rem <= trial - {1'b0, dmag};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
      nsh  <= {nsh[30:0], 1'b0};
      dcnt <= dcnt + 1'b1;
    end

    if (cmd.div_fin) begin
      ratio <= rovf ? sat_signmag(65'h1_0000_0000, rneg) : sat_signmag({33'b0, quo}, rneg);
    end

    if (cmd.mul_d) begin
      prod <= hp_mag * rmag;
      pneg <= hp[32] ^ ratio[31];
    end

    if (cmd.mul_c) begin
      dd[i] <= sat_signmag(prod >> FRAC_BITS, pneg);
      prod  <= ho_mag * rmag;
      pneg  <= ho[32] ^ ratio[31];
    end

    if (cmd.wr_c) begin
      cc[i] <= sat_signmag(prod >> FRAC_BITS, pneg);
      if (!sts.row_last) i <= i1;
    end

    if (cmd.path) begin
      dy <= dy_new;
      y  <= sat33(ysum);
      if (!take_c) k <= km1;
      m <= IDX_W'(m + 1'b1);
      i <= '0;
    end

    if (cmd.publish) begin
      rsp.interp_value   <= fail ? 32'sd0 : y;
      rsp.error_estimate <= fail ? 32'sd0 : dy;
      rsp.status         <= fail ? STATUS_ZERO_DEN : STATUS_OK;
    end
  end

endmodule

// File: hdl/neville_polynomial_interpolator.sv
// Neville polynomial interpolator over up to MAX_POINTS stored sample points.
// A word is accepted only while the block is idle. An evaluate word over n points
// works through the Neville tableau with the one shared radix-2
// divider (32 quotient bits, one per cycle) used for every tableau entry.
// The result register frees the input side while a result waits downstream.
// Synchronous reset sets points_used to 8; the sample table is not cleared.
module neville_polynomial_interpolator import npi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  req_t            req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output rsp_t            rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PU_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  npi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_command(req.command),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  npi_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .rsp     (rsp)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for neville_polynomial_interpolator: a self-checking bench with a
// built-in Neville predictor and randomized handshakes. Depends on npi_pkg.
module tb;
  import npi_pkg::*;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  req_t            req = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b1;
  rsp_t            rsp;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [PU_W-1:0] cfg_data = '0;

  neville_polynomial_interpolator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;

  // Shadow copy of the block's table and register.
  longint    table_x[8];
  longint    table_y[8];
  logic [3:0] shadow_pu = PU_RESET;
  rsp_t      pending_results[$];

  int errors = 0;
  int words_sent = 0;
  int evals_sent = 0;
  int results_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold_rsp = 1'b0;

  function automatic longint clamp32(longint v);
    return (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic rsp_t neville_eval(logic signed [31:0] query);
    rsp_t r;
    longint cc[8];
    longint dd[8];
    longint x, y, dy, best, gap, ho, hp, w, den, ratio;
    int n, k;
    r = '0;
    n = shadow_pu;
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    x = query;
    k = 0;
    best = mag(x - table_x[0]);
    for (int i = 0; i < n; i++) begin
      gap = mag(x - table_x[i]);
      if (gap < best) begin
        best = gap;
        k = i;
      end
      cc[i] = table_y[i];
      dd[i] = table_y[i];
    end
    y = table_y[k];
    dy = 0;
    for (int m = 1; m < n; m++) begin
      for (int i = 0; i < n - m; i++) begin
        ho = table_x[i] - x;
        hp = table_x[i + m] - x;
        w = cc[i + 1] - dd[i];
        den = ho - hp;
        if (den == 0) begin
          r.status = STATUS_ZERO_DEN;
          return r;
        end
        ratio = clamp32((w * ONE_Q) / den);
        dd[i] = clamp32((hp * ratio) / ONE_Q);
        cc[i] = clamp32((ho * ratio) / ONE_Q);
      end
      if (2 * k < n - m) begin
        dy = cc[k];
      end else begin
        dy = dd[k - 1];
        k--;
      end
      y = clamp32(y + dy);
    end
    r.interp_value = y[31:0];
    r.error_estimate = dy[31:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  // Offer one word; the predictor runs when the block takes it.
  task automatic send_word(req_t w);
    while ($urandom_range(99) < send_idle) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req = w;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    words_sent++;
    if (w.command == CMD_LOAD) begin
      table_x[w.point_index] = w.point_x;
      table_y[w.point_index] = w.point_y;
    end else begin
      evals_sent++;
      pending_results.push_back(neville_eval(w.query_x));
    end
    @(negedge clk);
  endtask

  task automatic load_point(int slot, logic [31:0] px, logic [31:0] py);
    req_t w;
    w = '0;
    w.command = CMD_LOAD;
    w.point_index = slot[2:0];
    w.point_x = px;
    w.point_y = py;
    w.query_x = $urandom;
    send_word(w);
  endtask

  task automatic evaluate(logic [31:0] qx);
    req_t w;
    w = '0;
    w.command = CMD_EVAL;
    w.point_index = 3'($urandom);
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.query_x = qx;
    send_word(w);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  // Writes only once the block is idle; loads leave no result to wait for,
  // so a short pause covers one still in flight.
  task automatic write_points_used(logic [3:0] v);
    drain();
    repeat (8) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_pu = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    rsp_stall = hold_rsp || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.interp_value !== exp_r.interp_value) begin
          $display("%0t: interp_value expected %h got %h", $time,
                   exp_r.interp_value, rsp.interp_value);
          errors++;
        end
        if (rsp.error_estimate !== exp_r.error_estimate) begin
          $display("%0t: error_estimate expected %h got %h", $time,
                   exp_r.error_estimate, rsp.error_estimate);
          errors++;
        end
        if (rsp.status !== exp_r.status) begin
          $display("%0t: status expected %b got %b", $time, exp_r.status, rsp.status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    for (int i = 0; i < 8; i++) load_point(i, i << 16, (i * i) << 15);
    evaluate(32'h0002_8000);
    evaluate(32'h0003_0000);
    evaluate(32'h8000_0000);
    evaluate(32'h7FFF_FFFF);
    load_point(7, 32'h7FFF_FFFF, 32'h8000_0000);
    load_point(6, 32'h8000_0000, 32'h7FFF_FFFF);
    evaluate(32'h0000_0000);
    evaluate(32'hFFFF_FFFF);
    write_points_used(4'd0);
    evaluate(32'h0000_4000);
    write_points_used(4'd1);
    evaluate(32'h0001_4000);
    write_points_used(4'd15);
    evaluate(32'h0004_8000);
    // Coincident abscissae give a zero denominator.
    load_point(1, 32'h0000_0000, 32'h1234_5678);
    evaluate(32'h0002_0000);
    write_points_used(4'd2);
    evaluate(32'h0000_1000);
    write_points_used(4'd8);
    drain();
  endtask

  // The receiver holds off while several cheap evaluations back up the input.
  task automatic test_backpressure();
    write_points_used(4'd2);
    load_point(0, 32'h0001_0000, 32'h0002_0000);
    load_point(1, 32'h0003_0000, 32'hFFFE_0000);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (3000) @(negedge clk);
        hold_rsp = 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) evaluate($urandom_range(32'h0005_0000));
    drain();
  endtask

  function automatic logic [31:0] scaled(int sh);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> sh;
  endfunction

  task automatic random_set();
    int n, sh, cnt;
    logic [3:0] pu;
    cnt = $urandom_range(99);
    pu = (cnt < 70) ? 4'($urandom_range(2, 4)) :
         (cnt < 90) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    write_points_used(pu);
    n = (pu < 2) ? 2 : (pu > 8) ? 8 : pu;
    sh = $urandom_range(0, 15);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(19) == 0)
        load_point(i, 32'(table_x[$urandom_range(i - 1)]), scaled($urandom_range(0, 15)));
      else
        load_point(i, scaled(sh), scaled($urandom_range(0, 15)));
    end
    cnt = $urandom_range(1, 3);
    for (int j = 0; j < cnt; j++) begin
      if ($urandom_range(3) == 0) evaluate(32'(table_x[$urandom_range(n - 1)]));
      else evaluate(scaled(sh));
    end
    if ($urandom_range(4) == 0) load_point($urandom_range(7), $urandom, $urandom);
  endtask

  task automatic test_random(int s_idle, int r_idle, int count);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = words_sent;
    while (words_sent - start < count) random_set();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random(24, 83, 470);
    test_random(83, 24, 470);
    test_random(0, 0, 470);
    write_points_used(4'd8);
    repeat (50) @(negedge clk);
    $display("tb: %0d words sent, %0d evaluations, %0d results checked", words_sent,
             evals_sent, results_seen);
    $display("tb: covered table sizes 0 to 15, saturation, zero denominators, stalls");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
